[sv/bfsp_pkg.sv]
// ----------------------------------------------------------------------------
// bfsp_pkg
// Types and constants for the shortest-path engine, including its RAM records.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsp_pkg;

    localparam int C_MAX_VERTICES = 64;
    localparam int C_MAX_EDGES    = 1024;
    localparam int C_WEIGHT_BITS  = 16;

    localparam int C_VIDX_W = 6;
    localparam int C_VCNT_W = 7;
    localparam int C_DIST_W = 32;
    localparam int C_EIDX_W = (C_MAX_EDGES > 1) ? $clog2(C_MAX_EDGES) : 1;
    localparam int C_ECNT_W = $clog2(C_MAX_EDGES + 1);

    localparam logic C_KIND_EDGE = 1'b0;
    localparam logic C_KIND_RUN  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [5:0]          edge_from;
        logic [5:0]          edge_to;
        logic signed [15:0]  edge_weight;
        logic [5:0]          start_vertex;
    } t_in_beat;

    typedef struct packed {
        logic [5:0]          vertex;
        logic signed [31:0]  distance;
        logic                reachable;
        logic [5:0]          predecessor;
        logic                has_predecessor;
        logic                negative_cycle;
        logic                edges_dropped;
        logic                last;
    } t_out_beat;

    typedef struct packed {
        logic [C_VIDX_W-1:0]      tail;
        logic [C_VIDX_W-1:0]      head;
        logic [C_WEIGHT_BITS-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic [C_VIDX_W-1:0] pred;
        logic [C_DIST_W-1:0] cost;
    } t_vrec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_EFETCH,
        S_ECHK,
        S_RDH,
        S_RELAX,
        S_OREAD,
        S_OWRITE
    } t_state;

endpackage

`default_nettype wire

[sv/bfsp_ram.sv]
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]                           i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]                           o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[sv/bellman_ford_shortest_path.sv]
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path
// Single-source shortest path over a loaded edge list, with saturated sums,
// predecessor tracking and negative-cycle detection.
//
//   Channel  Signals                          Content
//   -------  -------------------------------  ------------------------------
//   in       i_in_valid/o_in_ready/i_in_data  edge load or run request
//   out      o_out_valid/i_out_ready/o_out_data one result per vertex
//   cfg      i_cfg_we/i_cfg_data              vertex count register
//
// A run fetches and checks every edge in each pass; a usable edge then has
// its tail and head records read in turn from the one-read-port vertex RAM
// and is relaxed. Results are read out as the consumer accepts them.
// Reset is synchronous; no clearing pass is needed.
// New beats are refused from a run's start until its last result is stored.
// ----------------------------------------------------------------------------
`default_nettype none

module bellman_ford_shortest_path (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [6:0]           i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire bfsp_pkg::t_in_beat   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output bfsp_pkg::t_out_beat       o_out_data
);

    import bfsp_pkg::*;

    localparam int C_VRAM_AW = $clog2(C_MAX_VERTICES);

    t_state                    r_state, n_state;
    logic [C_VCNT_W-1:0]       r_vcount;
    logic [C_ECNT_W-1:0]       r_etotal, n_etotal;
    logic [C_EIDX_W-1:0]       r_eidx, n_eidx;
    logic [C_VCNT_W-1:0]       r_pass, n_pass;
    logic [C_VCNT_W-1:0]       r_oidx, n_oidx;
    logic                      r_drop, n_drop;
    logic                      r_detect, n_detect;
    logic                      r_changed, n_changed;
    logic                      r_neg, n_neg;
    logic [C_MAX_VERTICES-1:0] r_reached, n_reached;
    logic [C_MAX_VERTICES-1:0] r_pvalid, n_pvalid;
    logic [C_DIST_W-1:0]       r_nd, n_nd;
    logic                      r_ovalid, n_ovalid;
    t_out_beat                 r_out, n_out;

    logic [C_VCNT_W-1:0]       nv;
    logic                      eram_we, eram_re;
    logic [C_EIDX_W-1:0]       eram_waddr;
    t_edge                     eram_wdata, eram_rdata;
    logic                      vram_we, vram_re;
    logic [C_VRAM_AW-1:0]      vram_waddr, vram_raddr;
    t_vrec                     vram_wdata, vram_rdata;
    logic [C_DIST_W:0]         sum;
    logic                      in_acc;

    bfsp_ram #(
        .P_WIDTH ($bits(t_edge)),
        .P_DEPTH (C_MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (eram_we),
        .i_waddr (eram_waddr),
        .i_wdata (eram_wdata),
        .i_re    (eram_re),
        .i_raddr (r_eidx),
        .o_rdata (eram_rdata)
    );

    bfsp_ram #(
        .P_WIDTH ($bits(t_vrec)),
        .P_DEPTH (C_MAX_VERTICES)
    ) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (vram_waddr),
        .i_wdata (vram_wdata),
        .i_re    (vram_re),
        .i_raddr (vram_raddr),
        .o_rdata (vram_rdata)
    );

    always_comb begin
        if (r_vcount == '0) begin
            nv = C_VCNT_W'(1);
        end else if (r_vcount > C_VCNT_W'(C_MAX_VERTICES)) begin
            nv = C_VCNT_W'(C_MAX_VERTICES);
        end else begin
            nv = r_vcount;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign sum = {vram_rdata.cost[C_DIST_W-1], vram_rdata.cost}
               + {{(C_DIST_W + 1 - C_WEIGHT_BITS){eram_rdata.weight[C_WEIGHT_BITS-1]}},
                  eram_rdata.weight};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= C_VCNT_W'(C_MAX_VERTICES);
            r_etotal  <= '0;
            r_drop    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_reached <= '0;
            r_pvalid  <= '0;
            r_eidx    <= '0;
            r_pass    <= '0;
            r_oidx    <= '0;
            r_detect  <= 1'b0;
            r_changed <= 1'b0;
            r_neg     <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            r_etotal  <= n_etotal;
            r_drop    <= n_drop;
            r_ovalid  <= n_ovalid;
            r_reached <= n_reached;
            r_pvalid  <= n_pvalid;
            r_eidx    <= n_eidx;
            r_pass    <= n_pass;
            r_oidx    <= n_oidx;
            r_detect  <= n_detect;
            r_changed <= n_changed;
            r_neg     <= n_neg;
        end
        r_nd  <= n_nd;
        r_out <= n_out;
    end

    always_comb begin
        logic       adv;
        logic       chg;
        logic       better;
        logic [C_ECNT_W-1:0] next_e;

        n_state    = r_state;
        n_etotal   = r_etotal;
        n_eidx     = r_eidx;
        n_pass     = r_pass;
        n_oidx     = r_oidx;
        n_drop     = r_drop;
        n_detect   = r_detect;
        n_changed  = r_changed;
        n_neg      = r_neg;
        n_reached  = r_reached;
        n_pvalid   = r_pvalid;
        n_nd       = r_nd;
        n_out      = r_out;
        n_ovalid   = r_ovalid;
        eram_we    = 1'b0;
        eram_re    = 1'b0;
        eram_waddr = r_etotal[C_EIDX_W-1:0];
        eram_wdata = '{tail: i_in_data.edge_from, head: i_in_data.edge_to,
                       weight: i_in_data.edge_weight[C_WEIGHT_BITS-1:0]};
        vram_we    = 1'b0;
        vram_re    = 1'b0;
        vram_waddr = i_in_data.start_vertex[C_VRAM_AW-1:0];
        vram_wdata = '{pred: '0, cost: '0};
        vram_raddr = eram_rdata.tail[C_VRAM_AW-1:0];
        adv        = 1'b0;
        chg        = r_changed;
        better     = 1'b0;
        next_e     = C_ECNT_W'(r_eidx) + C_ECNT_W'(1);

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.kind == C_KIND_EDGE) begin
                        if (r_etotal == C_ECNT_W'(C_MAX_EDGES)
                            || {1'b0, i_in_data.edge_from} >= nv
                            || {1'b0, i_in_data.edge_to} >= nv) begin
                            n_drop = 1'b1;
                        end else begin
                            eram_we  = 1'b1;
                            n_etotal = r_etotal + C_ECNT_W'(1);
                        end
                    end else begin
                        n_reached = '0;
                        n_pvalid  = '0;
                        n_neg     = 1'b0;
                        n_pass    = '0;
                        n_oidx    = '0;
                        if ({1'b0, i_in_data.start_vertex} < nv) begin
                            vram_we = 1'b1;
                            n_reached[i_in_data.start_vertex[C_VRAM_AW-1:0]] = 1'b1;
                            n_detect = (nv == C_VCNT_W'(1));
                            n_state  = S_PASS;
                        end else begin
                            n_state = S_OREAD;
                        end
                    end
                end
            end
            S_PASS: begin
                n_eidx    = '0;
                n_changed = 1'b0;
                if (r_etotal == '0) begin
                    if (r_detect) begin
                        n_state = S_OREAD;
                    end else begin
                        n_detect = 1'b1;
                    end
                end else begin
                    n_state = S_EFETCH;
                end
            end
            S_EFETCH: begin
                eram_re = 1'b1;
                n_state = S_ECHK;
            end
            S_ECHK: begin
                if ({1'b0, eram_rdata.tail} >= nv || {1'b0, eram_rdata.head} >= nv
                    || !r_reached[eram_rdata.tail[C_VRAM_AW-1:0]]) begin
                    adv = 1'b1;
                end else begin
                    vram_re = 1'b1;
                    n_state = S_RDH;
                end
            end
            S_RDH: begin
                if (sum[C_DIST_W] != sum[C_DIST_W-1]) begin
                    n_nd = sum[C_DIST_W] ? {1'b1, {(C_DIST_W-1){1'b0}}}
                                         : {1'b0, {(C_DIST_W-1){1'b1}}};
                end else begin
                    n_nd = sum[C_DIST_W-1:0];
                end
                vram_re    = 1'b1;
                vram_raddr = eram_rdata.head[C_VRAM_AW-1:0];
                n_state    = S_RELAX;
            end
            S_RELAX: begin
                better = !r_reached[eram_rdata.head[C_VRAM_AW-1:0]]
                      || ($signed(r_nd) < $signed(vram_rdata.cost));
                if (better && r_detect) begin
                    n_neg   = 1'b1;
                    n_state = S_OREAD;
                end else begin
                    if (better) begin
                        vram_we    = 1'b1;
                        vram_waddr = eram_rdata.head[C_VRAM_AW-1:0];
                        vram_wdata = '{pred: eram_rdata.tail, cost: r_nd};
                        n_reached[eram_rdata.head[C_VRAM_AW-1:0]] = 1'b1;
                        n_pvalid[eram_rdata.head[C_VRAM_AW-1:0]]  = 1'b1;
                        n_changed = 1'b1;
                        chg       = 1'b1;
                    end
                    adv = 1'b1;
                end
            end
            S_OREAD: begin
                vram_raddr = r_oidx[C_VRAM_AW-1:0];
                if (!r_ovalid || i_out_ready) begin
                    vram_re = 1'b1;
                    n_state = S_OWRITE;
                end
            end
            S_OWRITE: begin
                n_ovalid              = 1'b1;
                n_out.vertex          = r_oidx[C_VIDX_W-1:0];
                n_out.reachable       = r_reached[r_oidx[C_VRAM_AW-1:0]];
                n_out.distance        = n_out.reachable ? vram_rdata.cost : '0;
                n_out.has_predecessor = n_out.reachable && r_pvalid[r_oidx[C_VRAM_AW-1:0]];
                n_out.predecessor     = n_out.has_predecessor ? vram_rdata.pred : '0;
                n_out.negative_cycle  = r_neg;
                n_out.edges_dropped   = r_drop;
                n_out.last            = (r_oidx + C_VCNT_W'(1) == nv);
                if (n_out.last) begin
                    n_etotal = '0;
                    n_drop   = 1'b0;
                    n_state  = S_IDLE;
                end else begin
                    n_oidx  = r_oidx + C_VCNT_W'(1);
                    n_state = S_OREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv) begin
            if (next_e == r_etotal) begin
                if (r_detect) begin
                    n_state = S_OREAD;
                end else if (chg && ({1'b0, r_pass} + 8'd2 < {1'b0, nv})) begin
                    n_pass  = r_pass + C_VCNT_W'(1);
                    n_state = S_PASS;
                end else begin
                    n_detect = 1'b1;
                    n_state  = S_PASS;
                end
            end else begin
                n_eidx  = next_e[C_EIDX_W-1:0];
                n_state = S_EFETCH;
            end
        end
    end

endmodule

`default_nettype wire
